// ----- sv/oipd_pkg.sv -----
// Package for the owned interrupt pending dispatcher.
// Holds table sizes, the entry, item, result and memory request types.
// No dependencies; every other file refers to it by scoped names.
package oipd_pkg;

  localparam int NUM_LINES   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int LINE_IDX_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  localparam int LINE_W  = 5;
  localparam int OWNER_W = 16;
  localparam int TAG_W   = 16;
  localparam int FUNC_W  = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  typedef logic [LINE_IDX_W-1:0]  line_idx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t    COUNT_MAX = '1;
  localparam count_t    COUNT_ONE = count_t'(1);
  localparam line_idx_t LAST_LINE = line_idx_t'(NUM_LINES - 1);
  localparam line_idx_t IDX_ONE   = line_idx_t'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BIND     = 2'd0,
    FUNC_EVENT    = 2'd1,
    FUNC_DISPATCH = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIND,
    ST_EVENT,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   handler;
    logic [OWNER_W-1:0] owner;
    count_t             count;
  } entry_t;

  typedef struct packed {
    func_t              func;
    logic [LINE_W-1:0]  line;
    logic [OWNER_W-1:0] owner_id;
    logic [TAG_W-1:0]   handler_tag;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [LINE_W-1:0]  found_line;
    logic [TAG_W-1:0]   found_handler;
  } result_t;

  typedef struct packed {
    logic      rd_en;
    line_idx_t rd_addr;
    logic      wr_en;
    line_idx_t wr_addr;
    entry_t    wr_data;
  } mem_req_t;

endpackage

// ----- sv/oipd_table.sv -----
// Line table memory: one entry per interrupt line, registered read port.
// A valid bit per entry makes unwritten entries read as all zero after reset.
// Depends on oipd_pkg.
module oipd_table (
  input  logic              clk,
  input  logic              rst,
  input  oipd_pkg::mem_req_t req,
  output oipd_pkg::entry_t   rd_data
);

  oipd_pkg::entry_t mem [oipd_pkg::NUM_LINES];
  logic [oipd_pkg::NUM_LINES-1:0] valid;
  oipd_pkg::entry_t rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ----- sv/oipd_ctrl.sv -----
// Sequencer for bind, event and dispatch, with the result output register.
// Reads, modifies and writes back entries of oipd_table; depends on oipd_pkg.
module oipd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  oipd_pkg::item_t    in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output oipd_pkg::result_t  out_res,
  output oipd_pkg::mem_req_t req,
  input  oipd_pkg::entry_t   rd_data
);

  oipd_pkg::state_t    state, state_next;
  oipd_pkg::item_t     item, item_next;
  oipd_pkg::line_idx_t scan_idx, scan_idx_next;
  oipd_pkg::result_t   res, res_next;
  logic                out_load;
  logic                in_range;
  logic                hit;
  logic                evt_ok;

  assign in_range = (int'(item.line) < oipd_pkg::NUM_LINES);
  assign hit = (rd_data.handler != '0) && (rd_data.owner == item.owner_id) &&
               (rd_data.count != '0);
  assign evt_ok = in_range && (rd_data.handler != '0) &&
                  (rd_data.count != oipd_pkg::COUNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oipd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    scan_idx <= scan_idx_next;
    res      <= res_next;
    if (out_load) begin
      out_res <= res;
    end
  end

  always_comb begin
    state_next    = state;
    item_next     = item;
    scan_idx_next = scan_idx;
    res_next      = res;
    req           = '0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    case (state)
      oipd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next = in_item;
          case (in_item.func)
            oipd_pkg::FUNC_BIND: begin
              state_next = oipd_pkg::ST_BIND;
            end
            oipd_pkg::FUNC_EVENT: begin
              req.rd_en   = 1'b1;
              req.rd_addr = oipd_pkg::line_idx_t'(in_item.line);
              state_next  = oipd_pkg::ST_EVENT;
            end
            oipd_pkg::FUNC_DISPATCH: begin
              req.rd_en     = 1'b1;
              req.rd_addr   = '0;
              scan_idx_next = '0;
              state_next    = oipd_pkg::ST_SCAN;
            end
            default: begin
              res_next   = '0;
              state_next = oipd_pkg::ST_RESULT;
            end
          endcase
        end
      end
      oipd_pkg::ST_BIND: begin
        req.wr_en           = in_range;
        req.wr_addr         = oipd_pkg::line_idx_t'(item.line);
        req.wr_data.handler = item.handler_tag;
        req.wr_data.owner   = item.owner_id;
        req.wr_data.count   = '0;
        res_next            = '0;
        res_next.accepted   = in_range;
        state_next          = oipd_pkg::ST_RESULT;
      end
      oipd_pkg::ST_EVENT: begin
        req.wr_en         = evt_ok;
        req.wr_addr       = oipd_pkg::line_idx_t'(item.line);
        req.wr_data       = rd_data;
        req.wr_data.count = rd_data.count + oipd_pkg::COUNT_ONE;
        res_next          = '0;
        res_next.accepted = evt_ok;
        state_next        = oipd_pkg::ST_RESULT;
      end
      oipd_pkg::ST_SCAN: begin
        if (hit) begin
          req.wr_en              = 1'b1;
          req.wr_addr            = scan_idx;
          req.wr_data            = rd_data;
          req.wr_data.count      = rd_data.count - oipd_pkg::COUNT_ONE;
          res_next.accepted      = 1'b1;
          res_next.found_line    = oipd_pkg::LINE_W'(scan_idx);
          res_next.found_handler = rd_data.handler;
          state_next             = oipd_pkg::ST_RESULT;
        end else if (scan_idx == oipd_pkg::LAST_LINE) begin
          res_next   = '0;
          state_next = oipd_pkg::ST_RESULT;
        end else begin
          scan_idx_next = scan_idx + oipd_pkg::IDX_ONE;
          req.rd_en     = 1'b1;
          req.rd_addr   = scan_idx + oipd_pkg::IDX_ONE;
        end
      end
      oipd_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = oipd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oipd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/owned_irq_pending_dispatcher.sv -----
// Top level of the owned interrupt pending dispatcher.
// Instantiates oipd_ctrl and oipd_table; uses oipd_pkg for types.
//
//   Channel  Direction  Fields (lowest bit up)
//   s_*      in         tuser: func; tdata: line, owner_id, handler_tag
//   m_*      out        tuser: accepted; tdata: found_line, found_handler
//
// One item is worked on at a time. Bind writes its entry in a single step;
// event reads the entry and writes it back; dispatch reads one table entry
// per cycle through the single memory read port, from line 0 up to the first
// matching line, or through every line when nothing matches.
// The next item is taken while a result still waits in the output register.
// Synchronous reset clears all lines to unbound at once; no clearing pass.
module owned_irq_pending_dispatcher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [4:0] line, [20:5] owner_id, [36:21] handler_tag, [39:37] zero
  input  logic [oipd_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [oipd_pkg::FUNC_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] found_line, [20:5] found_handler, [23:21] zero
  output logic [oipd_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] accepted
  output logic [0:0]                      m_tuser
);

  oipd_pkg::item_t    in_item;
  oipd_pkg::result_t  out_res;
  oipd_pkg::mem_req_t req;
  oipd_pkg::entry_t   rd_data;

  assign in_item.func        = oipd_pkg::func_t'(s_tuser);
  assign in_item.line        = s_tdata[4:0];
  assign in_item.owner_id    = s_tdata[20:5];
  assign in_item.handler_tag = s_tdata[36:21];

  assign m_tdata = {3'b000, out_res.found_handler, out_res.found_line};
  assign m_tuser = out_res.accepted;

  oipd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .req       (req),
    .rd_data   (rd_data)
  );

  oipd_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ----- sv/oipd_checker.sv -----
// Port-level checks for the owned interrupt pending dispatcher.
// Bound to owned_irq_pending_dispatcher below; depends on oipd_pkg.
module oipd_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [oipd_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [oipd_pkg::FUNC_W-1:0]    s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [oipd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                     m_tuser
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("Output valid or input not ready after reset.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("A second item was taken while one is in progress.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("A rejected result carries a nonzero line or handler.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("A stalled result changed or was dropped.");

endmodule

bind owned_irq_pending_dispatcher oipd_port_checks u_oipd_checker (.*);
